// File: hdl/nfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types and codes of the NFA recognizer: opcodes, register index,
// controller states and the slot load word handed to the state cells.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int SYM_W   = 8;  // symbol_value port width
    localparam int STATE_W = 4;  // from_state / to_state port width
    localparam int SLOT_W  = 3;  // slot_index port width
    localparam int CFG_W   = 5;  // state_count register width

    localparam logic [CFG_W-1:0] STATE_COUNT_RESET = 5'd1;

    // register index, taken from paddr[2]
    localparam logic REG_STATE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_SYMBOL = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] to_state;
        logic               slot_valid;
    } load_word_t;

endpackage

// File: hdl/nfa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_cell
// One automaton state: holds its transition slots, reads one slot per cycle
// and ORs its target into the next-set vector passed along the cell chain.
// ----------------------------------------------------------------------------
module nfa_cell #(
    parameter int CELL_ID  = 0,
    parameter int STATES   = 16,
    parameter int SLOTS    = 8,
    parameter int SYM_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_en,
    input  nfa_pkg::load_word_t load_word,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_slot,
    input  logic                scan_en,
    input  logic [SYM_BITS-1:0] sym,
    input  logic [$clog2(STATES+1)-1:0] cnt,
    input  logic [STATES-1:0]   chain_in,
    output logic [STATES-1:0]   chain_out
);
    import nfa_pkg::*;

    localparam int KW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]    enabled_reg;
    logic [SYM_BITS-1:0] sym_mem [SLOTS];
    logic [STATE_W-1:0]  tgt_mem [SLOTS];
    logic [KW-1:0]       wr_slot;
    logic [STATE_W-1:0]  tgt_rd;
    logic                in_use;
    logic                hit;
    logic [STATES-1:0]   contrib;

    assign wr_slot = KW'(load_word.slot_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= '0;
        end
        else if (load_en)
        begin
            enabled_reg[wr_slot] <= load_word.slot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            sym_mem[wr_slot] <= SYM_BITS'(load_word.symbol);
            tgt_mem[wr_slot] <= load_word.to_state;
        end
    end

    assign tgt_rd = tgt_mem[rd_slot];
    assign in_use = (32'(cnt) > CELL_ID);

    // targets at or beyond the state count add nothing
    assign hit = scan_en && in_use && enabled_reg[rd_slot] &&
                 (sym_mem[rd_slot] == sym) && (32'(tgt_rd) < 32'(cnt));

    always_comb
    begin
        for (int j = 0; j < STATES; j++)
        begin
            contrib[j] = hit && (32'(tgt_rd) == j);
        end
    end

    assign chain_out = chain_in | contrib;

endmodule

// File: hdl/nfa_recognizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_recognizer
// NFA string recognizer built as a chain of state cells with a small
// sequencing controller and an APB register for the state count.
// ----------------------------------------------------------------------------
// Each automaton state is one cell holding SLOTS_PER_STATE transition slots.
// A load word (opcode 0) writes one slot; opcode 3 is dropped. A start word
// resets the active set to state 0 and returns its result word through the
// EMIT state and the output register. A symbol word walks the slot rows, one
// row of every cell per cycle, and no next word is taken until the scan and
// the EMIT state are done. A result word sits in an output register, and
// stalls on out_ready only hold the block once it has a further result ready
// to hand over.
// ----------------------------------------------------------------------------
module nfa_recognizer #(
    parameter int MAX_STATES      = 16,
    parameter int SLOTS_PER_STATE = 8,
    parameter int SYMBOL_BITS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  symbol_value,
    input  logic [3:0]  from_state,
    input  logic [2:0]  slot_index,
    input  logic [3:0]  to_state,
    input  logic        slot_valid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        alive,
    output logic        accepted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nfa_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int NW = $clog2(MAX_STATES + 1);
    localparam int KW = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;

    logic [CFG_W-1:0]       state_count_reg;
    logic [NW-1:0]          cnt;
    ctrl_state_t            st_reg, st_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [MAX_STATES-1:0]  acc_reg, acc_next;
    logic [MAX_STATES-1:0]  active_reg, active_next;
    logic                   alive_reg, alive_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_alive_reg, out_alive_next;
    logic                   out_acc_reg, out_acc_next;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic                   accept;
    logic                   load_ok;
    logic                   out_free;
    logic                   scan_last;
    logic [MAX_STATES-1:0]  scan_set;
    logic [SW-1:0]          fin_idx;
    load_word_t             load_word;
    logic [MAX_STATES-1:0]  chain [MAX_STATES+1];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STATE_COUNT) ? 32'(state_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= STATE_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_STATE_COUNT))
        begin
            state_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    // states in use, clamped to 1..MAX_STATES
    always_comb
    begin
        if (state_count_reg == '0)
        begin
            cnt = NW'(1);
        end
        else if (32'(state_count_reg) > MAX_STATES)
        begin
            cnt = NW'(MAX_STATES);
        end
        else
        begin
            cnt = NW'(state_count_reg);
        end
    end

    assign fin_idx = SW'(cnt - NW'(1));

    assign in_ready = (st_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load_ok  = (opcode == OP_LOAD) && (32'(from_state) < MAX_STATES) &&
                      (32'(slot_index) < SLOTS_PER_STATE);

    assign load_word.slot_index = slot_index;
    assign load_word.symbol     = symbol_value;
    assign load_word.to_state   = to_state;
    assign load_word.slot_valid = slot_valid;

    // cell chain: next-set vector ripples from cell 0 to the last cell
    assign chain[0] = '0;

    for (genvar s = 0; s < MAX_STATES; s++)
    begin : g_cell
        nfa_cell #(
            .CELL_ID  (s),
            .STATES   (MAX_STATES),
            .SLOTS    (SLOTS_PER_STATE),
            .SYM_BITS (SYMBOL_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load_en   (accept && load_ok && (32'(from_state) == s)),
            .load_word (load_word),
            .rd_slot   (k_reg),
            .scan_en   ((st_reg == ST_SCAN) && alive_reg && active_reg[s]),
            .sym       (sym_reg),
            .cnt       (cnt),
            .chain_in  (chain[s]),
            .chain_out (chain[s+1])
        );
    end

    assign scan_set  = acc_reg | chain[MAX_STATES];
    assign scan_last = (st_reg == ST_SCAN) && (k_reg == KW'(SLOTS_PER_STATE - 1));

    always_comb
    begin
        st_next        = st_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        active_next    = active_reg;
        alive_next     = alive_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_alive_next = out_alive_reg;
        out_acc_next   = out_acc_reg;

        case (st_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_START))
                begin
                    active_next = MAX_STATES'(1);
                    alive_next  = 1'b1;
                    st_next     = ST_EMIT;
                end
                else if (accept && (opcode == OP_SYMBOL))
                begin
                    k_next   = '0;
                    acc_next = '0;
                    st_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                acc_next = scan_set;
                k_next   = k_reg + KW'(1);
                if (scan_last)
                begin
                    active_next = scan_set;
                    alive_next  = alive_reg && (scan_set != '0);
                    st_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_alive_next = alive_reg;
                    out_acc_next   = alive_reg && active_reg[fin_idx];
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            k_reg         <= '0;
            acc_reg       <= '0;
            active_reg    <= MAX_STATES'(1);
            alive_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            active_reg    <= active_next;
            alive_reg     <= alive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_alive_reg <= out_alive_next;
        out_acc_reg   <= out_acc_next;
        if (accept && (opcode == OP_SYMBOL))
        begin
            sym_reg <= SYMBOL_BITS'(symbol_value);
        end
    end

    assign out_valid = out_valid_reg;
    assign alive     = out_alive_reg;
    assign accepted  = out_acc_reg;

endmodule

// File: hdl/nfa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_chk
// Port-level checks of the NFA recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module nfa_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic       alive,
    input logic       accepted
);
    import nfa_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(alive) && $stable(accepted))
        else $error("result word changed while stalled");

    a_acc_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !accepted || alive)
        else $error("accepted without alive");

    // start and symbol words keep the block busy in the cycle after they are taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ((opcode == OP_START) || (opcode == OP_SYMBOL))
        |=> !in_ready)
        else $error("word taken while a result is pending");

    // a start word always reports a live string
    a_start_alive: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_START) && !out_valid
        |=> ##1 out_valid && alive)
        else $error("start word did not report alive");

endmodule

bind nfa_recognizer nfa_chk u_nfa_chk (.*);
